### sv/hrs_pkg.sv
// Shared types, command codes and report constants for the HID report segmenter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hrs_pkg;

  localparam int unsigned HRS_QUEUE_DEPTH = 4;

  localparam logic [7:0] CMD_STORE   = 8'h05;
  localparam logic [7:0] CMD_SAVE    = 8'h13;
  localparam logic [7:0] CMD_REFRESH = 8'h04;

  localparam logic [2:0] LAST_WORD_IDX = 3'd7;
  localparam logic [2:0] HDR_SLOT      = 3'd7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_message;
    logic [23:0] message_length;
  } in_t;

  typedef struct packed {
    logic [63:0] report_word;
    logic [2:0]  word_index;
    logic        last_of_packet;
    logic        last_of_run;
  } out_t;

  // One unit of work for the back end: a word at a given index, optionally padded
  // with zero words to the end of the report, optionally followed by save + refresh.
  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        pad;
    logic        store;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_SAVE,
    BK_REFRESH
  } bk_state_t;

  function automatic logic [63:0] hdr_word(logic [7:0] cmd, logic [23:0] len,
                                           logic [23:0] off);
    return {8'd0, off, len, cmd};
  endfunction

  localparam logic [63:0] SAVE_W0    = {CMD_SAVE, 24'd0, 24'd1, CMD_SAVE};
  localparam logic [63:0] REFRESH_W0 = {CMD_REFRESH, 24'd0, 24'd2, CMD_REFRESH};

endpackage

### sv/hrs_front.sv
// Front end: takes message bytes, tracks position, packs report words with headers.
// Pushes one job per completed word or message end. Depends on hrs_pkg.
`timescale 1ns / 1ps

module hrs_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  hrs_pkg::in_t in_data,
  input  logic         q_full,
  output logic         q_push,
  output hrs_pkg::job_t q_job
);
  import hrs_pkg::*;

  logic [7:0]  cmd_r, cmd_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] pos_r, pos_nxt;
  logic [55:0] acc_r, acc_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [2:0]  wc_r, wc_nxt;

  logic        accept;
  logic        first;
  logic [7:0]  cmd_e;
  logic [23:0] len_e;
  logic [23:0] pos_e;
  logic [63:0] acc_e;
  logic [2:0]  slot_e;
  logic [2:0]  wc_e;
  logic        active;
  logic        chunk_start;
  logic [2:0]  slot_use;
  logic [63:0] acc_ins;
  logic        word_full;
  logic [23:0] pos_inc;
  logic        ends;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign first    = in_data.first_of_message;

  always_comb begin
    cmd_e  = first ? in_data.data_byte : cmd_r;
    len_e  = first ? in_data.message_length : len_r;
    pos_e  = first ? 24'd0 : pos_r;
    acc_e  = first ? 64'd0 : {8'd0, acc_r};
    slot_e = first ? 3'd0 : slot_r;
    wc_e   = first ? 3'd0 : wc_r;

    active      = pos_e < len_e;
    chunk_start = (slot_e == 3'd0) && (wc_e == 3'd0);
    // the first word of a report is the 7-byte header plus one payload byte
    slot_use    = chunk_start ? HDR_SLOT : slot_e;
    acc_ins     = chunk_start ? hdr_word(cmd_e, len_e, pos_e) : acc_e;
    acc_ins[{slot_use, 3'b000} +: 8] = in_data.data_byte;
    word_full   = slot_use == HDR_SLOT;
    pos_inc     = pos_e + 24'd1;
    ends        = pos_inc == len_e;

    q_push      = accept && active && (word_full || ends);
    q_job.word  = acc_ins;
    q_job.idx   = wc_e;
    q_job.pad   = ends;
    q_job.store = ends && (cmd_e == CMD_STORE);

    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    slot_nxt = slot_r;
    wc_nxt   = wc_r;
    if (accept) begin
      cmd_nxt  = cmd_e;
      len_nxt  = len_e;
      pos_nxt  = pos_e;
      acc_nxt  = acc_e[55:0];
      slot_nxt = slot_e;
      wc_nxt   = wc_e;
      if (active) begin
        pos_nxt = pos_inc;
        if (ends) begin
          acc_nxt  = 56'd0;
          slot_nxt = 3'd0;
          wc_nxt   = 3'd0;
        end else if (word_full) begin
          acc_nxt  = 56'd0;
          slot_nxt = 3'd0;
          wc_nxt   = wc_e + 3'd1;
        end else begin
          acc_nxt  = acc_ins[55:0];
          slot_nxt = slot_use + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= '0;
      len_r  <= '0;
      pos_r  <= '0;
      acc_r  <= '0;
      slot_r <= '0;
      wc_r   <= '0;
    end else begin
      cmd_r  <= cmd_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      slot_r <= slot_nxt;
      wc_r   <= wc_nxt;
    end
  end

endmodule

### sv/hrs_fifo.sv
// Small job queue between front and back end; head is shown without a read cycle.
// Depends on hrs_pkg for the job type.
`timescale 1ns / 1ps

module hrs_fifo #(
  parameter int unsigned DEPTH = hrs_pkg::HRS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hrs_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output hrs_pkg::job_t head
);
  import hrs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### sv/hrs_back.sv
// Back end: expands queued jobs into report words (data, zero padding, save and
// refresh reports) and holds them in the output register. Depends on hrs_pkg.
`timescale 1ns / 1ps

module hrs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    profile,
  input  logic          q_valid,
  input  hrs_pkg::job_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output hrs_pkg::out_t out_data
);
  import hrs_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] word_r, word_nxt;
  logic        pad_r, pad_nxt;
  logic        store_r, store_nxt;
  out_t        out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        emit;
  logic        seg_end;
  logic        run_end;
  logic [63:0] cur_word;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    pad_nxt       = pad_r;
    store_nxt     = store_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    cur_word      = 64'd0;
    seg_end       = idx_r == LAST_WORD_IDX;
    run_end       = 1'b0;

    emit = (state_r != BK_IDLE) && (!out_valid_r || out_ready);

    case (state_r)
      BK_DATA: begin
        cur_word = word_r;
        seg_end  = !pad_r || (idx_r == LAST_WORD_IDX);
        run_end  = seg_end && !store_r;
      end
      BK_SAVE: begin
        cur_word = (idx_r == 3'd0) ? SAVE_W0 : 64'd0;
      end
      BK_REFRESH: begin
        if (idx_r == 3'd0) begin
          cur_word = REFRESH_W0;
        end else if (idx_r == 3'd1) begin
          cur_word = {61'd0, profile};
        end
        run_end = seg_end;
      end
      default: begin
        cur_word = 64'd0;
      end
    endcase

    if (emit) begin
      out_nxt.report_word    = cur_word;
      out_nxt.word_index     = idx_r;
      out_nxt.last_of_packet = idx_r == LAST_WORD_IDX;
      out_nxt.last_of_run    = run_end;
      out_valid_nxt          = 1'b1;
      if (!seg_end) begin
        idx_nxt  = idx_r + 3'd1;
        word_nxt = 64'd0;
      end else if (state_r == BK_DATA && store_r) begin
        state_nxt = BK_SAVE;
        idx_nxt   = 3'd0;
      end else if (state_r == BK_SAVE) begin
        state_nxt = BK_REFRESH;
        idx_nxt   = 3'd0;
      end else begin
        state_nxt = BK_IDLE;
      end
    end

    // next job goes in right behind the last word of the current one
    if ((state_r == BK_IDLE || (emit && run_end)) && q_valid) begin
      q_pop     = 1'b1;
      state_nxt = BK_DATA;
      idx_nxt   = q_head.idx;
      word_nxt  = q_head.word;
      pad_nxt   = q_head.pad;
      store_nxt = q_head.store;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    word_r  <= word_nxt;
    pad_r   <= pad_nxt;
    store_r <= store_nxt;
    out_r   <= out_nxt;
  end

endmodule

### sv/hid_report_segmenter.sv
// Top level of the HID report segmenter: profile register, front end, job queue
// and back end. Depends on hrs_pkg, hrs_front, hrs_fifo and hrs_back.
//
// Usage: message bytes enter on in_valid/in_ready/in_data, one request per byte;
// the byte marked first_of_message carries the command and the total length.
// Reports leave on out_valid/out_ready/out_data as eight 64-bit words each, the
// earliest byte in bits 7:0, with word_index, last_of_packet and last_of_run.
// cfg_wr_en/cfg_wr_data set the profile byte used in the refresh report.
// Throughput: one byte per cycle on input while the queue has room; output runs one
// word per cycle while out_ready is high. A byte that completes a word yields one
// word; a message end yields up to 8 words, plus 16 more for a store command.
// A completed word passes through the job queue and the back end's job registers
// into the output register. The job queue (QUEUE_DEPTH entries) absorbs bursts;
// in_ready drops only when it is full.
// Reset (synchronous, rst_n low): queue and message state clear, profile
// returns to 1. When out_ready is low with a word valid, the output word holds and
// the back end waits; the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps

module hid_report_segmenter #(
  parameter int unsigned QUEUE_DEPTH = hrs_pkg::HRS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hrs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hrs_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_wr_data
);
  import hrs_pkg::*;

  logic [2:0] profile_r, profile_nxt;
  logic       q_push;
  job_t       q_job;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  job_t       q_head;

  assign profile_nxt = cfg_wr_en ? cfg_wr_data : profile_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= 3'd1;
    end else begin
      profile_r <= profile_nxt;
    end
  end

  hrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  hrs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  hrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .profile   (profile_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sv/hrs_checker.sv
// Port-level checks on the segmenter's result channel, bound to the top level.
// Depends on hrs_pkg and hid_report_segmenter.
`timescale 1ns / 1ps

module hrs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input hrs_pkg::out_t out_data
);
  import hrs_pkg::*;

  logic [2:0] exp_idx_r, exp_idx_nxt;

  // word indexes run on from the last word sent; an abandoned message cuts its
  // report short, so a fresh report may start at 0 at any point
  assign exp_idx_nxt = (out_valid && out_ready) ? out_data.word_index + 3'd1 : exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_last_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_of_packet == (out_data.word_index == LAST_WORD_IDX))
    else $error("last_of_packet does not match word index");

  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.word_index == exp_idx_r) || (out_data.word_index == 3'd0))
    else $error("report word out of sequence");

endmodule

bind hid_report_segmenter hrs_checker u_hrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### verif/hrs_tb_pkg.sv
// Scoreboard for the HID report segmenter: predicts the report words for every
// accepted byte request and checks the words that leave the block.
// Depends on hrs_pkg for the payload types and command codes.
`timescale 1ns / 1ps

package hrs_tb_pkg;

  import hrs_pkg::*;

  class report_scoreboard;

    bit [2:0]    profile;
    bit [7:0]    command;
    bit [23:0]   msg_length;
    bit [23:0]   position;
    bit [63:0]   partial;
    bit [3:0]    slot;
    bit [2:0]    word_count;
    out_t        run_words[$];
    out_t        expected_words[$];
    int unsigned mismatches;
    int unsigned words_checked;

    function new();
      profile       = 3'd1;
      command       = 8'd0;
      msg_length    = 24'd0;
      position      = 24'd0;
      partial       = 64'd0;
      slot          = 4'd0;
      word_count    = 3'd0;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    function void set_profile(bit [2:0] value);
      profile = value;
    endfunction

    function bit [63:0] header_word(bit [7:0] cmd, bit [23:0] len, bit [23:0] off);
      return {8'h00, off, len, cmd};
    endfunction

    function void push_word(bit [63:0] word, bit [2:0] idx);
      out_t r;
      r.report_word    = word;
      r.word_index     = idx;
      r.last_of_packet = (idx == LAST_WORD_IDX);
      r.last_of_run    = 1'b0;
      run_words.push_back(r);
    endfunction

    // save/refresh report: header plus a one- or two-byte payload
    function void push_short(bit [7:0] cmd, bit [23:0] len, bit [7:0] second);
      int i;
      push_word(header_word(cmd, len, 24'd0) | {cmd, 56'd0}, 3'd0);
      push_word((len > 24'd1) ? {56'd0, second} : 64'd0, 3'd1);
      for (i = 2; i < 8; i++) push_word(64'd0, 3'(i));
    endfunction

    function void take_byte(in_t item);
      int   i;
      out_t tail;
      run_words.delete();
      if (item.first_of_message) begin
        command    = item.data_byte;
        msg_length = item.message_length;
        position   = 24'd0;
        partial    = 64'd0;
        slot       = 4'd0;
        word_count = 3'd0;
      end
      if (position >= msg_length) return;

      // start of a report: header fills bytes 0..6, payload begins in the top byte
      if (slot == 4'd0 && word_count == 3'd0) begin
        partial = header_word(command, msg_length, position);
        slot    = 4'(HDR_SLOT);
      end
      partial |= 64'(item.data_byte) << (8 * slot);
      slot++;
      if (slot == 4'd8) begin
        push_word(partial, word_count);
        partial = 64'd0;
        slot    = 4'd0;
        word_count++;
      end
      position++;

      if (position == msg_length) begin
        if (slot != 4'd0 || word_count != 3'd0) begin
          push_word(partial, word_count);
          for (i = int'(word_count) + 1; i < 8; i++) push_word(64'd0, 3'(i));
        end
        partial    = 64'd0;
        slot       = 4'd0;
        word_count = 3'd0;
        if (command == CMD_STORE) begin
          push_short(CMD_SAVE, 24'd1, 8'd0);
          push_short(CMD_REFRESH, 24'd2, {5'd0, profile});
        end
      end

      if (run_words.size() > 0) begin
        tail = run_words.pop_back();
        tail.last_of_run = 1'b1;
        run_words.push_back(tail);
      end
      foreach (run_words[k]) expected_words.push_back(run_words[k]);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        $error("report_word: expected none, actual %h (index %0d)",
               got.report_word, got.word_index);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      compare_field("report_word", want.report_word, got.report_word);
      compare_field("word_index", 64'(want.word_index), 64'(got.word_index));
      compare_field("last_of_packet", 64'(want.last_of_packet), 64'(got.last_of_packet));
      compare_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
    endfunction

  endclass

endpackage

### verif/testbench.sv
// Top-level testbench for hid_report_segmenter: drives byte requests, profile
// writes and output backpressure, and checks every word against the scoreboard.
// Depends on hrs_pkg, hrs_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  import hrs_pkg::*;
  import hrs_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam bit [2:0] PROFILE_SEQ [PHASE_COUNT] =
    '{3'd7, 3'd0, 3'd4, 3'd1, 3'd3, 3'd2, 3'd6, 3'd5};

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_LONG_STALL
  } sink_mode_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  in_t        in_data     = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  out_t       out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [2:0] cfg_wr_data = 3'd0;

  report_scoreboard board = new();

  sink_mode_t  sink_mode      = SINK_OPEN;
  int unsigned sink_period    = 6;
  int unsigned sink_hold      = 2;
  int unsigned sink_tick      = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_max        = 0;
  int unsigned message_bytes  = 0;
  int unsigned messages_sent  = 0;
  int unsigned store_messages = 0;
  int unsigned profiles_used  = 0;
  bit          message_open   = 1'b0;

  hid_report_segmenter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver backpressure, pattern chosen per phase
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    case (sink_mode)
      SINK_OPEN:       out_ready <= 1'b1;
      SINK_RANDOM:     out_ready <= ($urandom_range(99, 0) < 70);
      SINK_PERIODIC:   out_ready <= ((sink_tick % sink_period) >= sink_hold);
      SINK_LONG_STALL: out_ready <= ((sink_tick % 40) >= 20);
      default:         out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_word(out_data);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // one byte request; the sender idles between bursts of random length when gap_max is nonzero
  task automatic send_byte(bit [7:0] data, bit first, bit [23:0] len);
    in_t         item;
    int unsigned gap;
    item.data_byte        = data;
    item.first_of_message = first;
    item.message_length   = len;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.take_byte(item);
  endtask

  // sends up to keep bytes of a message of length len; the first byte always goes
  task automatic send_message(bit [7:0] cmd, bit [23:0] len, int unsigned keep);
    int unsigned i;
    send_byte(cmd, 1'b1, len);
    message_bytes++;
    for (i = 1; i < keep && i < len; i++) begin
      send_byte(8'($urandom_range(255, 0)), 1'b0, 24'($urandom));
      message_bytes++;
    end
    messages_sent++;
    if (cmd == CMD_STORE) store_messages++;
  endtask

  // budget caps the bytes sent so a phase stays near its size
  task automatic random_message(int unsigned budget);
    int unsigned pick;
    int unsigned keep;
    bit [7:0]    cmd;
    bit [23:0]   len;
    pick = $urandom_range(99, 0);
    // stray bytes outside a message should be dropped
    if (pick < 5 && !message_open) begin
      repeat ($urandom_range(3, 1))
        send_byte(8'($urandom_range(255, 0)), 1'b0, 24'($urandom));
      return;
    end
    pick = $urandom_range(99, 0);
    if (pick < 30)      cmd = CMD_STORE;
    else if (pick < 38) cmd = CMD_SAVE;
    else if (pick < 44) cmd = CMD_REFRESH;
    else                cmd = 8'($urandom_range(255, 0));

    pick = $urandom_range(99, 0);
    if (pick < 3)       len = 24'd0;
    else if (pick < 6)  len = 24'($urandom_range(24'hFFFFFF, 24'h800000));
    else if (pick < 50) len = 24'($urandom_range(12, 1));
    else if (pick < 78) len = 24'($urandom_range(70, 13));
    else if (pick < 94) begin
      case ($urandom_range(8, 0))
        0:       len = 24'd7;
        1:       len = 24'd8;
        2:       len = 24'd9;
        3:       len = 24'd56;
        4:       len = 24'd57;
        5:       len = 24'd58;
        6:       len = 24'd64;
        7:       len = 24'd65;
        default: len = 24'd114;
      endcase
    end else            len = 24'($urandom_range(200, 71));

    keep = len;
    if (len > 24'd200) keep = $urandom_range(10, 1);
    else if (len > 24'd1 && $urandom_range(99, 0) < 15) keep = $urandom_range(len - 1, 1);
    if (keep > budget) keep = budget;
    message_open = (keep < len);
    send_message(cmd, len, keep);
  endtask

  // block drained: nothing expected, then a settling wait for work that yields no word
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_profile(bit [2:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    board.set_profile(value);
    cfg_wr_en   <= 1'b0;
    profiles_used++;
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    int unsigned period;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray byte, zero length, one-byte messages, store follow-ups,
    // an abandoned maximum-length message, two-word runs and a dropped partial
    send_byte(8'hFF, 1'b0, 24'hFFFFFF);
    send_message(8'h00, 24'd0, 1);
    send_message(8'hFF, 24'd1, 1);
    send_message(CMD_STORE, 24'd1, 1);
    send_message(8'hAA, 24'hFFFFFF, 3);
    send_message(8'h5A, 24'd9, 9);
    send_message(CMD_SAVE, 24'd57, 2);
    send_message(CMD_REFRESH, 24'd2, 2);
    message_open = 1'b0;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      write_profile(PROFILE_SEQ[phase]);
      period       = $urandom_range(9, 4);
      sink_mode   <= sink_mode_t'(phase % 4);
      sink_period <= period;
      sink_hold   <= $urandom_range(period - 1, 1);
      gap_max      = (phase % 3 == 0) ? 0 : $urandom_range(8, 2);
      burst_left   = 0;
      start        = message_bytes;
      while (message_bytes - start < PHASE_ITEMS)
        random_message(PHASE_ITEMS - (message_bytes - start));
    end

    wait_idle();
    $display("Run covered %0d messages (%0d store) in %0d message bytes, %0d profiles",
             messages_sent, store_messages, message_bytes, profiles_used);
    $display("Words checked: %0d, mismatches: %0d", board.words_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
